FILE: rtl/fspt_pkg.sv
// Shared types and constants for the force sensor peak trigger.
package fspt_pkg;

	localparam int unsigned SampleW = 16;
	localparam int unsigned RegIdxW = 3;

	typedef logic [SampleW-1:0] sample_t;

	typedef enum logic [RegIdxW-1:0] {
		REG_SMOOTH_POLE     = 3'd0,
		REG_DECAY_POLE      = 3'd1,
		REG_NOISE_MARGIN    = 3'd2,
		REG_MINIMUM_PEAK    = 3'd3,
		REG_STRENGTH_OFFSET = 3'd4,
		REG_STRENGTH_SCALE  = 3'd5
	} reg_idx_t;

	localparam sample_t SmoothPoleRst     = 16'd52429;
	localparam sample_t DecayPoleRst      = 16'd65470;
	localparam sample_t NoiseMarginRst    = 16'd655;
	localparam sample_t MinimumPeakRst    = 16'd6554;
	localparam sample_t StrengthOffsetRst = 16'd2048;
	localparam sample_t StrengthScaleRst  = 16'd43236;

	typedef struct packed {
		sample_t smooth_pole;
		sample_t decay_pole;
		sample_t noise_margin;
		sample_t minimum_peak;
		sample_t strength_offset;
		sample_t strength_scale;
	} cfg_t;

	typedef struct packed {
		sample_t smoothed;
		sample_t peak;
		logic    fire;
		sample_t strength;
	} result_t;

endpackage

FILE: rtl/fspt_cfg.sv
// Configuration register file of the force sensor peak trigger.
module fspt_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [fspt_pkg::RegIdxW-1:0]   cfg_index,
	input  fspt_pkg::sample_t              cfg_data,
	output fspt_pkg::cfg_t                 cfg
);
	import fspt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.smooth_pole     <= SmoothPoleRst;
			cfg_q.decay_pole      <= DecayPoleRst;
			cfg_q.noise_margin    <= NoiseMarginRst;
			cfg_q.minimum_peak    <= MinimumPeakRst;
			cfg_q.strength_offset <= StrengthOffsetRst;
			cfg_q.strength_scale  <= StrengthScaleRst;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SMOOTH_POLE:     cfg_q.smooth_pole     <= cfg_data;
				REG_DECAY_POLE:      cfg_q.decay_pole      <= cfg_data;
				REG_NOISE_MARGIN:    cfg_q.noise_margin    <= cfg_data;
				REG_MINIMUM_PEAK:    cfg_q.minimum_peak    <= cfg_data;
				REG_STRENGTH_OFFSET: cfg_q.strength_offset <= cfg_data;
				REG_STRENGTH_SCALE:  cfg_q.strength_scale  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/fspt_peak.sv
// Lowpass, leaky peak tracker and trigger: one item per step.
module fspt_peak (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  fspt_pkg::sample_t    raw,
	input  fspt_pkg::cfg_t       cfg,
	output fspt_pkg::result_t    result
);
	import fspt_pkg::*;

	sample_t filtered_q;
	sample_t held_peak_q;
	logic    has_fired_q;

	logic [2*SampleW-1:0] prev_prod;
	logic [2*SampleW:0]   raw_prod;
	logic [SampleW:0]     raw_weight;
	logic [2*SampleW:0]   acc;
	sample_t              smoothed;
	logic                 rising;
	logic                 fire;
	logic [2*SampleW-1:0] decay_prod;
	sample_t              decayed;
	sample_t              excess;
	logic [2*SampleW-1:0] scale_prod;
	logic [SampleW:0]     strength_sum;
	sample_t              strength_sat;

	// The two weights sum to one, so the accumulator never reaches bit 32.
	assign raw_weight = {1'b1, {SampleW{1'b0}}} - {1'b0, cfg.smooth_pole};
	assign prev_prod  = cfg.smooth_pole * filtered_q;
	assign raw_prod   = raw_weight * {1'b0, raw};
	assign acc        = {1'b0, prev_prod} + raw_prod;
	assign smoothed   = acc[2*SampleW-1:SampleW];

	assign rising = (smoothed >= held_peak_q);
	assign fire   = !rising && ((held_peak_q - smoothed) > cfg.noise_margin) &&
		!has_fired_q && (held_peak_q >= cfg.minimum_peak);

	// Decay and strength depend only on the held peak and the registers, in parallel with the lowpass.
	assign decay_prod = held_peak_q * cfg.decay_pole;
	assign decayed    = decay_prod[2*SampleW-1:SampleW];

	assign excess       = (held_peak_q >= cfg.minimum_peak) ?
		(held_peak_q - cfg.minimum_peak) : '0;
	assign scale_prod   = excess * cfg.strength_scale;
	assign strength_sum = {1'b0, cfg.strength_offset} +
		{1'b0, scale_prod[2*SampleW-1:SampleW]};
	assign strength_sat = strength_sum[SampleW] ? {SampleW{1'b1}} : strength_sum[SampleW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q  <= '0;
			held_peak_q <= '0;
			has_fired_q <= 1'b0;
		end else if (step_en) begin
			filtered_q <= smoothed;
			if (rising) begin
				held_peak_q <= smoothed;
				has_fired_q <= 1'b0;
			end else begin
				held_peak_q <= decayed;
				if (fire) begin
					has_fired_q <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		result.smoothed = smoothed;
		result.peak     = rising ? smoothed : held_peak_q;
		result.fire     = fire;
		result.strength = fire ? strength_sat : '0;
	end

	// The trigger only arms again after a rise, which also loads the smoothed level as the peak.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(has_fired_q) |-> $past(step_en) && $past(fire))
		else $error("fired flag set without a fire");
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(has_fired_q) |-> $past(step_en) && $past(rising))
		else $error("fired flag cleared without a rising sample");
	assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(held_peak_q) && $stable(filtered_q))
		else $error("state changed without a step");

endmodule

FILE: rtl/force_sensor_peak_trigger_core.sv
// An accepted item waits in the input register; its result goes to the result register.
// Throughput: one item per cycle unless out_ready stalls the result register; the lowpass
// multiply-add and peak compare sit between the input register and the result register,
// which also closes the loop on the filtered level and held peak.
// Reset: arst_n clears the registers to their defaults, the filtered level,
// held peak and fired flag to zero, and empties both pipeline registers.
module force_sensor_peak_trigger_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [fspt_pkg::RegIdxW-1:0] cfg_index,
	input  fspt_pkg::sample_t            cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  fspt_pkg::sample_t            raw_sample,
	output logic                         out_valid,
	input  logic                         out_ready,
	output fspt_pkg::sample_t            smoothed_sample,
	output fspt_pkg::sample_t            peak_level,
	output logic                         fire,
	output fspt_pkg::sample_t            strength
);
	import fspt_pkg::*;

	cfg_t    cfg;
	result_t step_result;
	result_t result_q;
	sample_t raw_s1;
	logic    valid_s1;
	logic    out_valid_q;
	logic    advance;

	// The stage-1 item moves on whenever the result register is free or drains.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	fspt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fspt_peak u_peak (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.raw     (raw_s1),
		.cfg     (cfg),
		.result  (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			raw_s1 <= raw_sample;
		end
		if (advance) begin
			result_q <= step_result;
		end
	end

	assign out_valid       = out_valid_q;
	assign smoothed_sample = result_q.smoothed;
	assign peak_level      = result_q.peak;
	assign fire            = result_q.fire;
	assign strength        = result_q.strength;

	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && out_valid_q && !out_ready)
		else $error("input stalled while the pipeline could move");
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("advanced item did not reach the result register");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.fire |-> result_q.peak > result_q.smoothed)
		else $error("fire reported without a fall below the peak");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.fire |-> result_q.strength == '0)
		else $error("strength reported without a fire");

endmodule

FILE: bench/tb_force_sensor_peak_trigger_core.sv
// Testbench for the force sensor peak trigger core: a directed table, then random presses and samples.
module tb_force_sensor_peak_trigger_core;
	import fspt_pkg::*;

	// Indexes past the last register; writes to them must change nothing.
	localparam logic [RegIdxW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [RegIdxW-1:0] REG_SPARE_HI = 3'd7;
	localparam int unsigned MaxShown = 10;
	localparam int unsigned ItemsPerPhase = 70;
	localparam int unsigned PhaseCount = 10;

	typedef struct packed {
		logic                is_cfg;
		logic                typed;
		logic [RegIdxW-1:0]  idx;
		sample_t             val;
		result_t             want;
	} step_row_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [RegIdxW-1:0] cfg_index;
	sample_t            cfg_data;
	logic               in_valid;
	logic               in_ready;
	sample_t            raw_sample;
	logic               out_valid;
	logic               out_ready;
	sample_t            smoothed_sample;
	sample_t            peak_level;
	logic               fire;
	sample_t            strength;

	// Shadow of the block: its registers, filtered level, held peak and fired flag.
	cfg_t        cfg_shadow;
	sample_t     level_q;
	sample_t     peak_q;
	logic        fired_q;
	result_t     pending_q[$];
	step_row_t   steps[$];
	int unsigned error_count;
	int unsigned mismatch_count;
	int unsigned samples_sent;
	bit          quiet;

	force_sensor_peak_trigger_core dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.raw_sample      (raw_sample),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.smoothed_sample (smoothed_sample),
		.peak_level      (peak_level),
		.fire            (fire),
		.strength        (strength)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic result_t track_sample(input sample_t raw);
		logic [47:0] acc;
		logic [47:0] prod;
		logic [16:0] sum;
		result_t     r;
		acc = 48'(cfg_shadow.smooth_pole) * 48'(level_q)
			+ (48'd65536 - 48'(cfg_shadow.smooth_pole)) * 48'(raw);
		r.smoothed = acc[31:16];
		r.fire = 1'b0;
		r.strength = '0;
		level_q = r.smoothed;
		if (r.smoothed >= peak_q) begin
			peak_q = r.smoothed;
			fired_q = 1'b0;
			r.peak = peak_q;
		end else begin
			if ((peak_q - r.smoothed) > cfg_shadow.noise_margin && !fired_q &&
					peak_q >= cfg_shadow.minimum_peak) begin
				fired_q = 1'b1;
				r.fire = 1'b1;
				prod = 48'(peak_q - cfg_shadow.minimum_peak) * 48'(cfg_shadow.strength_scale);
				sum = 17'(cfg_shadow.strength_offset) + 17'(prod[31:16]);
				r.strength = sum[16] ? 16'hFFFF : sum[15:0];
			end
			r.peak = peak_q;
			prod = 48'(peak_q) * 48'(cfg_shadow.decay_pole);
			peak_q = prod[31:16];
		end
		return r;
	endfunction

	function automatic int unsigned gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic sample_t pick_value(input int unsigned lo, input int unsigned hi);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h0000;
		else if (r == 1)
			return 16'hFFFF;
		return sample_t'($urandom_range(lo, hi));
	endfunction

	function automatic sample_t clamp_level(input int v);
		if (v < 0)
			return 16'h0000;
		if (v > 65535)
			return 16'hFFFF;
		return sample_t'(v);
	endfunction

	task automatic rest(input int unsigned n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Holds the sender off until every expected result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_q.size() != 0);
	endtask

	task automatic write_reg(input logic [RegIdxW-1:0] idx, input sample_t val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SMOOTH_POLE:     cfg_shadow.smooth_pole = val;
			REG_DECAY_POLE:      cfg_shadow.decay_pole = val;
			REG_NOISE_MARGIN:    cfg_shadow.noise_margin = val;
			REG_MINIMUM_PEAK:    cfg_shadow.minimum_peak = val;
			REG_STRENGTH_OFFSET: cfg_shadow.strength_offset = val;
			REG_STRENGTH_SCALE:  cfg_shadow.strength_scale = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic push_sample(input sample_t raw, input logic typed, input result_t want);
		result_t guess;
		in_valid <= 1'b1;
		raw_sample <= raw;
		do @(posedge clk); while (!in_ready);
		guess = track_sample(raw);
		pending_q.push_back(typed ? want : guess);
		samples_sent++;
		if (!quiet && $urandom_range(0, 99) < 30)
			rest(gap_len());
	endtask

	task automatic add_cfg(input logic [RegIdxW-1:0] idx, input sample_t val);
		step_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		steps.push_back(row);
	endtask

	task automatic add_sample(input sample_t raw);
		step_row_t row;
		row = '0;
		row.val = raw;
		steps.push_back(row);
	endtask

	task automatic add_known(input sample_t raw, input sample_t s, input sample_t p,
			input logic f, input sample_t st);
		step_row_t row;
		row = '0;
		row.typed = 1'b1;
		row.val = raw;
		row.want.smoothed = s;
		row.want.peak = p;
		row.want.fire = f;
		row.want.strength = st;
		steps.push_back(row);
	endtask

	// A press: a ramp up to a random top, then a ramp down, both with jitter.
	// A cut press ends with one random item instead of the fall.
	task automatic send_press(input logic cut);
		int unsigned base;
		int unsigned top;
		int unsigned rise;
		int unsigned fall;
		int unsigned k;
		int          jitter;
		int          lvl;
		base = $urandom_range(0, 3000);
		top = $urandom_range(base, 65535);
		rise = $urandom_range(1, 8);
		fall = $urandom_range(1, 12);
		jitter = $urandom_range(0, 600);
		for (k = 1; k <= rise; k++) begin
			lvl = int'(base + (top - base) * k / rise) + int'($urandom_range(0, 2 * jitter)) - jitter;
			push_sample(clamp_level(lvl), 1'b0, '0);
		end
		if (cut) begin
			push_sample(sample_t'($urandom_range(0, 65535)), 1'b0, '0);
		end else begin
			for (k = 1; k <= fall; k++) begin
				lvl = int'(top - (top - base) * k / fall) + int'($urandom_range(0, 2 * jitter))
					- jitter;
				push_sample(clamp_level(lvl), 1'b0, '0);
			end
		end
	endtask

	initial begin : receiver
		int unsigned hold;
		out_ready = 1'b0;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (quiet) begin
				out_ready <= 1'b1;
				hold = 0;
			end else if (hold != 0) begin
				hold--;
			end else if (out_ready) begin
				if ($urandom_range(0, 99) < 25) begin
					out_ready <= 1'b0;
					hold = gap_len() - 1;
				end
			end else begin
				out_ready <= 1'b1;
				hold = $urandom_range(0, 20);
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				error_count++;
				mismatch_count++;
				if (mismatch_count <= MaxShown)
					$display("unexpected result: smoothed %0d peak %0d fire %0d strength %0d",
						smoothed_sample, peak_level, fire, strength);
			end else begin
				want = pending_q.pop_front();
				if (smoothed_sample !== want.smoothed || peak_level !== want.peak ||
						fire !== want.fire || strength !== want.strength) begin
					error_count++;
					mismatch_count++;
					if (mismatch_count <= MaxShown)
						$display("mismatch: smoothed %0d/%0d peak %0d/%0d fire %0d/%0d strength %0d/%0d",
							want.smoothed, smoothed_sample, want.peak, peak_level,
							want.fire, fire, want.strength, strength);
				end
			end
		end
	end

	initial begin : stimulus
		int unsigned ph;
		int unsigned start;
		int unsigned kind;
		int unsigned spin;
		bit          drained;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		raw_sample = '0;
		quiet = 1'b0;
		error_count = 0;
		mismatch_count = 0;
		samples_sent = 0;
		cfg_shadow.smooth_pole = SmoothPoleRst;
		cfg_shadow.decay_pole = DecayPoleRst;
		cfg_shadow.noise_margin = NoiseMarginRst;
		cfg_shadow.minimum_peak = MinimumPeakRst;
		cfg_shadow.strength_offset = StrengthOffsetRst;
		cfg_shadow.strength_scale = StrengthScaleRst;
		level_q = '0;
		peak_q = '0;
		fired_q = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// From reset a zero item equals the zero peak, which counts as rising.
		add_known(16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
		add_sample(16'd65535);
		add_sample(16'd65535);
		add_sample(16'd1);
		add_sample(16'd40000);
		// Pass-through filter and full decay make the results easy to read.
		add_cfg(REG_SMOOTH_POLE, 16'd0);
		add_cfg(REG_DECAY_POLE, 16'd0);
		add_cfg(REG_NOISE_MARGIN, 16'd0);
		add_cfg(REG_MINIMUM_PEAK, 16'd0);
		add_cfg(REG_STRENGTH_OFFSET, 16'd65535);
		add_cfg(REG_STRENGTH_SCALE, 16'd65535);
		add_known(16'd65535, 16'd65535, 16'd65535, 1'b0, 16'd0);
		add_known(16'd0, 16'd0, 16'd65535, 1'b1, 16'd65535);
		add_known(16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
		// A peak exactly at the minimum fires with zero excess; one below does not.
		add_cfg(REG_STRENGTH_OFFSET, 16'd0);
		add_cfg(REG_MINIMUM_PEAK, 16'd65535);
		add_known(16'd65535, 16'd65535, 16'd65535, 1'b0, 16'd0);
		add_known(16'd0, 16'd0, 16'd65535, 1'b1, 16'd0);
		add_known(16'd0, 16'd0, 16'd0, 1'b0, 16'd0);
		add_known(16'd65534, 16'd65534, 16'd65534, 1'b0, 16'd0);
		add_known(16'd0, 16'd0, 16'd65534, 1'b0, 16'd0);
		// Slowest decay and the widest margin, then a margin of 100.
		add_cfg(REG_DECAY_POLE, 16'd65535);
		add_cfg(REG_NOISE_MARGIN, 16'd65535);
		add_cfg(REG_MINIMUM_PEAK, 16'd1000);
		add_known(16'd40000, 16'd40000, 16'd40000, 1'b0, 16'd0);
		add_known(16'd0, 16'd0, 16'd40000, 1'b0, 16'd0);
		add_known(16'd0, 16'd0, 16'd39999, 1'b0, 16'd0);
		add_cfg(REG_NOISE_MARGIN, 16'd100);
		add_known(16'd39898, 16'd39898, 16'd39998, 1'b0, 16'd0);
		add_sample(16'd39896);
		add_sample(16'd0);
		add_sample(16'd39995);
		add_sample(16'd0);
		add_cfg(REG_SPARE_LO, 16'd0);
		add_cfg(REG_SPARE_HI, 16'd65535);
		add_cfg(REG_SMOOTH_POLE, 16'd65535);
		add_sample(16'd65535);
		add_sample(16'd65535);
		add_sample(16'd0);

		foreach (steps[k]) begin
			if (steps[k].is_cfg) begin
				settle();
				write_reg(steps[k].idx, steps[k].val);
			end else begin
				push_sample(steps[k].val, steps[k].typed, steps[k].want);
			end
		end

		for (ph = 0; ph < PhaseCount; ph++) begin
			settle();
			quiet = (ph == 3 || ph == 7);
			write_reg(REG_SMOOTH_POLE, pick_value(0, 60000));
			write_reg(REG_DECAY_POLE, pick_value(55000, 65535));
			write_reg(REG_NOISE_MARGIN, pick_value(0, 3000));
			write_reg(REG_MINIMUM_PEAK, pick_value(0, 20000));
			write_reg(REG_STRENGTH_OFFSET, pick_value(0, 65535));
			write_reg(REG_STRENGTH_SCALE, pick_value(0, 65535));
			start = samples_sent;
			drained = 0;
			while (samples_sent - start < ItemsPerPhase) begin
				kind = $urandom_range(0, 9);
				if (kind < 7)
					send_press(1'b0);
				else if (kind < 9)
					repeat ($urandom_range(1, 6))
						push_sample(sample_t'($urandom_range(0, 65535)), 1'b0, '0);
				else
					send_press(1'b1);
				if (!drained && samples_sent - start >= ItemsPerPhase / 2) begin
					settle();
					drained = 1;
				end
			end
		end

		in_valid <= 1'b0;
		spin = 0;
		do begin
			@(posedge clk);
			spin++;
		end while (pending_q.size() != 0 && spin < 20000);
		repeat (8) @(posedge clk);
		error_count += pending_q.size();
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: force_sensor_peak_trigger_core.f
rtl/fspt_pkg.sv
rtl/fspt_cfg.sv
rtl/fspt_peak.sv
rtl/force_sensor_peak_trigger_core.sv
bench/tb_force_sensor_peak_trigger_core.sv
